@@ hdl/hfd_pkg.sv @@
// Shared types and constants of the humidity/temperature frame decoder.
// Depends on nothing; used by the front end, the back end and the top level.
`timescale 1ns / 1ps

package hfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] BUSY_BIT = 8'h80;
	localparam logic [7:0] CAL_MASK = 8'h18;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	localparam int RAW_W = 20;
	localparam int HUM_W = 14;
	localparam int TMP_W = 15;

	localparam logic [HUM_W-1:0] HUM_SCALE = 14'd10000;
	localparam logic [TMP_W-1:0] TMP_SCALE = 15'd20000;
	localparam logic [TMP_W-1:0] TMP_OFFSET = 15'd5000;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BUSY    = 2'd1,
		ST_CRC_ERR = 2'd2,
		ST_UNCAL   = 2'd3
	} status_t;

	// Classified frame, handed from front to back.
	typedef struct packed {
		status_t          status;
		logic [RAW_W-1:0] raw_hum;
		logic [RAW_W-1:0] raw_tmp;
	} frame_t;

	// Converted result, held in the output queue.
	typedef struct packed {
		status_t                 status;
		logic [HUM_W-1:0]        hum_centi;
		logic signed [TMP_W-1:0] tmp_centi;
		logic [RAW_W-1:0]        raw_hum;
		logic [RAW_W-1:0]        raw_tmp;
	} result_t;

	// CRC-8, MSB first, one byte.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/humidity_temp_frame_decoder_core.sv @@
// Humidity/temperature frame decoder, top level.
// Throughput: one byte per cycle while full is low, set by the combinational CRC and field
// update in the front. Results pass from the frame queue through one multiply stage into the
// result queue, draining one per cycle while it is not full; full rises only when the frame
// queue fills. Reset (arst_n low, asynchronous) empties both queues and idles the front.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_core #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [7:0]                        frame_byte,
	input  logic                              frame_start,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        frame_status,
	output logic [hfd_pkg::HUM_W-1:0]         humidity_centi,
	output logic signed [hfd_pkg::TMP_W-1:0]  temperature_centi,
	output logic [hfd_pkg::RAW_W-1:0]         humidity_field,
	output logic [hfd_pkg::RAW_W-1:0]         temperature_field
);

	logic             mid_wr, mid_full, mid_empty, mid_pop;
	hfd_pkg::frame_t  mid_wdata, mid_rdata;
	logic             out_push, out_full;
	hfd_pkg::result_t out_wdata, out_rdata;

	hfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.frame_byte  (frame_byte),
		.frame_start (frame_start),
		.rec_wr      (mid_wr),
		.rec_data    (mid_wdata),
		.rec_full    (mid_full)
	);

	hfd_fifo #(
		.WIDTH ($bits(hfd_pkg::frame_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	hfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (mid_empty),
		.in_data  (mid_rdata),
		.in_pop   (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (out_wdata)
	);

	hfd_fifo #(
		.WIDTH ($bits(hfd_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_wdata),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_rdata),
		.empty   (empty)
	);

	assign frame_status      = out_rdata.status;
	assign humidity_centi    = out_rdata.hum_centi;
	assign temperature_centi = out_rdata.tmp_centi;
	assign humidity_field    = out_rdata.raw_hum;
	assign temperature_field = out_rdata.raw_tmp;

	a_mid_wr_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		mid_wr |-> (push && !full && !frame_start))
		else $error("frame record written without an accepted CRC byte");

	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_wr |-> !mid_full)
		else $error("frame queue written while full");

	a_mid_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("frame queue read while empty");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue written while full");

endmodule

@@ hdl/hfd_fifo.sv @@
// Small first-word-fall-through queue in flip-flops.
// Generic; no package dependency.
`timescale 1ns / 1ps

module hfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/hfd_front.sv @@
// Front end: takes frame bytes, runs the CRC, assembles raw fields, classifies status.
// Depends on hfd_pkg.
`timescale 1ns / 1ps

module hfd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [7:0]     frame_byte,
	input  logic           frame_start,
	output logic           rec_wr,
	output hfd_pkg::frame_t rec_data,
	input  logic           rec_full
);

	localparam logic [2:0] POS_IDLE = 3'd0;
	localparam logic [2:0] POS_HUM0 = 3'd1;
	localparam logic [2:0] POS_HUM1 = 3'd2;
	localparam logic [2:0] POS_SPLIT = 3'd3;
	localparam logic [2:0] POS_TMP0 = 3'd4;
	localparam logic [2:0] POS_TMP1 = 3'd5;
	localparam logic [2:0] POS_CRC = 3'd6;

	logic [2:0]                 pos_q;
	logic [7:0]                 crc_q;
	logic [7:0]                 status_q;
	logic [hfd_pkg::RAW_W-1:0]  hum_q, tmp_q;
	logic                       accept;
	hfd_pkg::status_t           code;

	assign full   = rec_full;
	assign accept = push && !full;
	assign rec_wr = accept && !frame_start && (pos_q == POS_CRC);

	always_comb begin
		if ((status_q & hfd_pkg::BUSY_BIT) != '0) begin
			code = hfd_pkg::ST_BUSY;
		end else if (crc_q != frame_byte) begin
			code = hfd_pkg::ST_CRC_ERR;
		end else if ((status_q & hfd_pkg::CAL_MASK) != hfd_pkg::CAL_MASK) begin
			code = hfd_pkg::ST_UNCAL;
		end else begin
			code = hfd_pkg::ST_OK;
		end
	end

	assign rec_data.status  = code;
	assign rec_data.raw_hum = hum_q;
	assign rec_data.raw_tmp = tmp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_IDLE;
			crc_q    <= hfd_pkg::CRC_INIT;
			status_q <= '0;
			hum_q    <= '0;
			tmp_q    <= '0;
		end else if (accept) begin
			if (frame_start) begin
				// restart, dropping any partial frame
				status_q <= frame_byte;
				crc_q    <= hfd_pkg::crc8_update(hfd_pkg::CRC_INIT, frame_byte);
				hum_q    <= '0;
				tmp_q    <= '0;
				pos_q    <= POS_HUM0;
			end else begin
				case (pos_q) inside
					POS_HUM0, POS_HUM1: begin
						hum_q <= {hum_q[hfd_pkg::RAW_W-9:0], frame_byte};
						crc_q <= hfd_pkg::crc8_update(crc_q, frame_byte);
						pos_q <= pos_q + 1'b1;
					end
					POS_SPLIT: begin
						hum_q <= {hum_q[hfd_pkg::RAW_W-5:0], frame_byte[7:4]};
						tmp_q <= hfd_pkg::RAW_W'(frame_byte[3:0] & hfd_pkg::NIBBLE_MASK);
						crc_q <= hfd_pkg::crc8_update(crc_q, frame_byte);
						pos_q <= pos_q + 1'b1;
					end
					POS_TMP0, POS_TMP1: begin
						tmp_q <= {tmp_q[hfd_pkg::RAW_W-9:0], frame_byte};
						crc_q <= hfd_pkg::crc8_update(crc_q, frame_byte);
						pos_q <= pos_q + 1'b1;
					end
					POS_CRC: begin
						pos_q <= POS_IDLE;
					end
					default: begin
						// stray byte while idle: drop
					end
				endcase
			end
		end
	end

endmodule

@@ hdl/hfd_back.sv @@
// Back end: scales raw fields to hundredths, one multiply stage, then into the result queue.
// Depends on hfd_pkg.
`timescale 1ns / 1ps

module hfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_empty,
	input  hfd_pkg::frame_t  in_data,
	output logic             in_pop,
	input  logic             out_full,
	output logic             out_push,
	output hfd_pkg::result_t out_data
);

	localparam int HP_W = hfd_pkg::RAW_W + hfd_pkg::HUM_W;
	localparam int TP_W = hfd_pkg::RAW_W + hfd_pkg::TMP_W;

	logic                      valid_s1;
	logic [HP_W-1:0]           hum_prod_s1;
	logic [TP_W-1:0]           tmp_prod_s1;
	hfd_pkg::status_t          status_s1;
	logic [hfd_pkg::RAW_W-1:0] raw_hum_s1, raw_tmp_s1;
	logic                      load;
	logic [hfd_pkg::TMP_W-1:0] tmp_int;

	assign out_push = valid_s1 && !out_full;
	assign load     = !valid_s1 || out_push;
	assign in_pop   = load && !in_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= !in_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			hum_prod_s1 <= HP_W'(in_data.raw_hum) * HP_W'(hfd_pkg::HUM_SCALE);
			tmp_prod_s1 <= TP_W'(in_data.raw_tmp) * TP_W'(hfd_pkg::TMP_SCALE);
			status_s1   <= in_data.status;
			raw_hum_s1  <= in_data.raw_hum;
			raw_tmp_s1  <= in_data.raw_tmp;
		end
	end

	// drop the 20 fraction bits, then remove the offset (wraps like the 15-bit field)
	assign tmp_int = tmp_prod_s1[TP_W-1:hfd_pkg::RAW_W];

	assign out_data.status    = status_s1;
	assign out_data.hum_centi = hum_prod_s1[HP_W-1:hfd_pkg::RAW_W];
	assign out_data.tmp_centi = signed'(tmp_int - hfd_pkg::TMP_OFFSET);
	assign out_data.raw_hum   = raw_hum_s1;
	assign out_data.raw_tmp   = raw_tmp_s1;

endmodule

@@ tb/hfd_frame_checker.sv @@
// Frame checker for the humidity/temperature frame decoder: decodes every accepted
// byte on its own and compares each popped word with the oldest decoded frame.
// Depends on hfd_pkg for the status codes, result layout and CRC constants.
`timescale 1ns / 1ps

package hfd_tb_pkg;

	// CRC-8 over one byte, one bit at a time, MSB first.
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? hfd_pkg::CRC_POLY : 8'h00);
		end
		return c;
	endfunction

endpackage

module hfd_frame_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic                             full,
	input  logic [7:0]                       frame_byte,
	input  logic                             frame_start,
	input  logic                             empty,
	input  logic                             pop,
	input  logic [1:0]                       frame_status,
	input  logic [hfd_pkg::HUM_W-1:0]        humidity_centi,
	input  logic signed [hfd_pkg::TMP_W-1:0] temperature_centi,
	input  logic [hfd_pkg::RAW_W-1:0]        humidity_field,
	input  logic [hfd_pkg::RAW_W-1:0]        temperature_field,
	output int                               failures,
	output int                               waiting,
	output int                               compared
);

	import hfd_pkg::*;
	import hfd_tb_pkg::*;

	logic [2:0]       next_index;
	logic [7:0]       crc_acc;
	logic [7:0]       status_reg;
	logic [RAW_W-1:0] hum_raw;
	logic [RAW_W-1:0] tmp_raw;
	result_t          frames_due[$];

	task automatic decode_byte(input logic [7:0] b, input logic s);
		result_t r;
		longint t;
		if (s) begin
			// a start always opens a new frame, dropping any partial one
			status_reg = b;
			crc_acc = crc8_next(CRC_INIT, b);
			hum_raw = '0;
			tmp_raw = '0;
			next_index = 3'd1;
			return;
		end
		case (next_index)
			3'd1, 3'd2: hum_raw = {hum_raw[RAW_W-9:0], b};
			3'd3: begin
				hum_raw = {hum_raw[RAW_W-5:0], b[7:4]};
				tmp_raw = {{(RAW_W-4){1'b0}}, b[3:0]};
			end
			3'd4, 3'd5: tmp_raw = {tmp_raw[RAW_W-9:0], b};
			3'd6: begin
				if ((status_reg & BUSY_BIT) != 8'h00) begin
					r.status = ST_BUSY;
				end else if (crc_acc != b) begin
					r.status = ST_CRC_ERR;
				end else if ((status_reg & CAL_MASK) != CAL_MASK) begin
					r.status = ST_UNCAL;
				end else begin
					r.status = ST_OK;
				end
				t = (longint'(hum_raw) * 10000) >>> 20;
				r.hum_centi = t[HUM_W-1:0];
				t = ((longint'(tmp_raw) * 20000) >>> 20) - 5000;
				r.tmp_centi = t[TMP_W-1:0];
				r.raw_hum = hum_raw;
				r.raw_tmp = tmp_raw;
				frames_due.push_back(r);
				next_index = 3'd0;
				return;
			end
			// idle: drop bytes that come without a start
			default: return;
		endcase
		crc_acc = crc8_next(crc_acc, b);
		next_index = next_index + 3'd1;
	endtask

	task automatic check_field(input string what, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			next_index = 3'd0;
			crc_acc = CRC_INIT;
			status_reg = 8'h00;
			hum_raw = '0;
			tmp_raw = '0;
			frames_due.delete();
		end else begin
			if (push && !full) begin
				decode_byte(frame_byte, frame_start);
			end
			if (pop && !empty) begin
				if (frames_due.size() == 0) begin
					$display("%0t: word popped with no frame decoded, status %0d", $time,
						frame_status);
					failures++;
				end else begin
					want = frames_due.pop_front();
					check_field("frame_status", want.status, frame_status);
					check_field("humidity_centi", want.hum_centi, humidity_centi);
					check_field("temperature_centi", want.tmp_centi, temperature_centi);
					check_field("humidity_field", want.raw_hum, humidity_field);
					check_field("temperature_field", want.raw_tmp, temperature_field);
					compared++;
				end
			end
		end
		waiting = frames_due.size();
	end

endmodule

@@ tb/tb_humidity_temp_frame_decoder_core.sv @@
// Testbench top for humidity_temp_frame_decoder_core: drives frame bytes and pops
// results with random gaps; hfd_frame_checker does the checking beside the block.
// Depends on hfd_pkg, hfd_frame_checker.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder_core;

	import hfd_pkg::*;
	import hfd_tb_pkg::*;

	localparam int WORD_TARGET = 1800;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 2000;

	logic                    clk;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic [7:0]              frame_byte;
	logic                    frame_start;
	logic                    empty;
	logic                    pop;
	logic [1:0]              frame_status;
	logic [HUM_W-1:0]        humidity_centi;
	logic signed [TMP_W-1:0] temperature_centi;
	logic [RAW_W-1:0]        humidity_field;
	logic [RAW_W-1:0]        temperature_field;

	int failures;
	int waiting;
	int compared;
	int words_sent;
	int stray_words;
	int frames_sent;
	int popped;
	int stall_count;

	humidity_temp_frame_decoder_core u_top (.*);

	hfd_frame_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
		end
		if (stall_count >= STALL_LIMIT) begin
			$display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one byte after a random gap; hold it until it is taken.
	task automatic send_word(input logic [7:0] b, input logic s);
		int gap;
		gap = ((words_sent % 200) < 40) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			push <= 1'b0;
			frame_byte <= 8'($urandom);
			frame_start <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		frame_byte <= b;
		frame_start <= s;
		do @(posedge clk); while (full);
		@(negedge clk);
		words_sent++;
	endtask

	// Send the first len bytes of a frame; the CRC byte is right or deliberately wrong.
	task automatic send_frame(input logic [7:0] st, input logic [39:0] body,
		input bit good_crc, input int len);
		logic [7:0] crc;
		logic [7:0] bytes [7];
		bytes[0] = st;
		crc = crc8_next(CRC_INIT, st);
		for (int i = 1; i <= 5; i++) begin
			bytes[i] = body[47-8*i -: 8];
			crc = crc8_next(crc, bytes[i]);
		end
		bytes[6] = good_crc ? crc : crc ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < len; i++) begin
			send_word(bytes[i], i == 0);
		end
		if (len == 7) begin
			frames_sent++;
		end
	endtask

	// Lean data bytes toward the all-zero and all-one extremes.
	function automatic logic [7:0] body_byte();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			return 8'h00;
		end else if (pick < 30) begin
			return 8'hFF;
		end
		return 8'($urandom);
	endfunction

	// Receiver: random wait before each pop, bursts with none, and two long hold-offs.
	initial begin
		int wait_cycles;
		pop = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (popped == 30 || popped == 160) begin
				wait_cycles = HOLD_CYCLES;
			end else if ((popped % 50) < 10) begin
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 10);
			end
			if (wait_cycles > 0) begin
				pop <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
			popped++;
		end
	end

	initial begin
		logic [7:0]  st;
		logic [39:0] body;
		bit          good;
		int          len;
		int          pick;
		arst_n = 1'b0;
		push = 1'b0;
		frame_byte = 8'h00;
		frame_start = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray byte while idle, then minimum fields, busy over bad CRC,
		// a frame cut short by a new start, and an uncalibrated frame at maximum
		send_word(8'hA5, 1'b0);
		stray_words++;
		send_frame(8'h18, 40'h00_0000_0000, 1'b1, 7);
		send_frame(8'h98, {5{8'hFF}}, 1'b0, 7);
		send_frame(8'h10, 40'h12_3456_789A, 1'b1, 2);
		send_frame(8'h08, {5{8'hFF}}, 1'b1, 7);

		while (words_sent - stray_words < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			st = (pick < 65) ? ({1'b0, 7'($urandom)} | CAL_MASK) : 8'($urandom);
			for (int k = 0; k < 5; k++) begin
				body = {body[31:0], body_byte()};
			end
			good = $urandom_range(0, 99) < 80;
			len = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 6) : 7;
			send_frame(st, body, good, len);
			if (len == 7 && $urandom_range(0, 99) < 5) begin
				repeat ($urandom_range(1, 3)) begin
					send_word(8'($urandom), 1'b0);
					stray_words++;
				end
			end
		end
		push <= 1'b0;

		while (waiting != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Covered %0d frame bytes in %0d whole frames plus %0d stray bytes;",
			words_sent - stray_words, frames_sent, stray_words);
		$display("%0d results compared; receiver held off twice for %0d cycles.",
			compared, HOLD_CYCLES);
		if (failures == 0 && waiting == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d decoded frames never popped", failures, waiting);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/hfd_pkg.sv
hdl/hfd_fifo.sv
hdl/hfd_front.sv
hdl/hfd_back.sv
hdl/humidity_temp_frame_decoder_core.sv
tb/hfd_frame_checker.sv
tb/tb_humidity_temp_frame_decoder_core.sv
